>>> hdl/sha256_pkg.sv
// Package for the SHA-256 message hasher: request/result structs, constants,
// round constant table and command/status structs between controller and datapath.
package sha256_pkg;

  localparam int WordWidth = 32;
  localparam int BlockWords = 16;
  localparam int Rounds = 64;
  localparam int DigestWords = 8;
  localparam int ByteCountWidth = 61;

  typedef struct packed {
    logic [31:0] message_word;
    logic        final_word;
    logic [2:0]  valid_bytes;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_digest_word;
  } out_req_t;

  localparam logic [1:0] WSEL_INPUT = 2'd0;
  localparam logic [1:0] WSEL_ZERO  = 2'd1;
  localparam logic [1:0] WSEL_LENHI = 2'd2;
  localparam logic [1:0] WSEL_LENLO = 2'd3;

  typedef struct packed {
    logic       push;
    logic [1:0] wsel;
    logic       pad_full;
    logic       start;
    logic       round;
    logic       finish;
    logic       count;
    logic       clear;
    logic [2:0] emit_index;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] words_in_block;
    logic       block_full;
  } dp_status_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

endpackage

>>> hdl/sha256_datapath.sv
// SHA-256 datapath: block buffer, byte count, rolling schedule, one round per cycle.
// Depends on sha256_pkg; driven by sha256_control.
module sha256_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  sha256_pkg::dp_cmd_t    cmd,
  input  sha256_pkg::in_req_t    req,
  output sha256_pkg::dp_status_t status,
  output logic [31:0]            digest_word
);

  logic [31:0] chain [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [3:0]  words_in_block;
  logic [60:0] byte_count;
  logic [5:0]  round_idx;
  logic [2:0]  nbytes;
  logic [31:0] in_word;
  logic [31:0] push_word;
  logic [63:0] bit_len;
  logic [31:0] s0, s1, w_new, big0, big1, ch, maj, t1, t2, wr;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    nbytes = (req.valid_bytes > 3'd4) ? 3'd4 : req.valid_bytes;
    in_word = req.message_word;
    if (req.final_word) begin
      case (nbytes)
        3'd0: in_word = 32'h80000000;
        3'd1: in_word = {req.message_word[31:24], 24'h800000};
        3'd2: in_word = {req.message_word[31:16], 16'h8000};
        3'd3: in_word = {req.message_word[31:8], 8'h80};
        default: in_word = req.message_word;
      endcase
    end
    bit_len = {byte_count, 3'b000};
    case (cmd.wsel)
      sha256_pkg::WSEL_INPUT: push_word = cmd.pad_full ? 32'h80000000 : in_word;
      sha256_pkg::WSEL_ZERO:  push_word = 32'h0;
      sha256_pkg::WSEL_LENHI: push_word = bit_len[63:32];
      default:                push_word = bit_len[31:0];
    endcase
  end

  always_comb begin
    s0 = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
    s1 = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
    w_new = s1 + w[9] + s0 + w[0];
    wr = w[0];
    big1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + big1 + ch + sha256_pkg::round_k(round_idx) + wr;
    big0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = big0 + maj;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      w[words_in_block] <= push_word;
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end else if (cmd.round) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::init_hash(3'(i));
      words_in_block <= '0;
      byte_count <= '0;
      round_idx <= '0;
    end else begin
      if (cmd.finish) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
      end
      if (cmd.push) words_in_block <= words_in_block + 4'd1;
      if (cmd.count) begin
        byte_count <= byte_count + (req.final_word ? 61'(nbytes) : 61'd4);
      end
      if (cmd.start) round_idx <= '0;
      else if (cmd.round) round_idx <= round_idx + 6'd1;
    end
  end

  assign status.words_in_block = words_in_block;
  assign status.block_full = (words_in_block == 4'd15);
  assign digest_word = chain[cmd.emit_index];

endmodule

>>> hdl/sha256_control.sv
// SHA-256 controller: accepts requests, sequences padding, rounds and digest output.
// Depends on sha256_pkg; commands sha256_datapath.
module sha256_control (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  sha256_pkg::in_req_t    req,
  output logic                   in_stall,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [2:0]             out_index,
  output sha256_pkg::dp_cmd_t    cmd,
  input  sha256_pkg::dp_status_t status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PADW  = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state, state_next;
  logic [5:0] rcount, rcount_next;
  logic       padding, padding_next;
  logic       pad_pend, pad_pend_next;
  logic       len_hi, len_hi_next;
  logic       lastblk, lastblk_next;
  logic [2:0] idx, idx_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = (state == S_EMIT);
  assign out_index = idx;

  always_comb begin
    state_next = state;
    rcount_next = rcount;
    padding_next = padding;
    pad_pend_next = pad_pend;
    len_hi_next = len_hi;
    lastblk_next = lastblk;
    idx_next = idx;
    cmd = '0;
    cmd.wsel = sha256_pkg::WSEL_INPUT;
    cmd.emit_index = idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.push = 1'b1;
          cmd.count = 1'b1;
          if (req.final_word) begin
            padding_next = 1'b1;
            pad_pend_next = (req.valid_bytes >= 3'd4);
            if (req.valid_bytes >= 3'd4) state_next = S_PADW;
            else state_next = S_FILL;
          end
          if (status.block_full) begin
            cmd.start = 1'b1;
            rcount_next = '0;
            state_next = S_RUN;
          end
        end
      end
      S_PADW: begin
        cmd.push = 1'b1;
        cmd.pad_full = 1'b1;
        pad_pend_next = 1'b0;
        state_next = S_FILL;
        if (status.block_full) begin
          cmd.start = 1'b1;
          rcount_next = '0;
          state_next = S_RUN;
        end
      end
      S_FILL: begin
        cmd.push = 1'b1;
        if (status.words_in_block == 4'd14) begin
          cmd.wsel = sha256_pkg::WSEL_LENHI;
          len_hi_next = 1'b1;
        end else if (status.words_in_block == 4'd15 && len_hi) begin
          cmd.wsel = sha256_pkg::WSEL_LENLO;
          padding_next = 1'b0;
          len_hi_next = 1'b0;
          lastblk_next = 1'b1;
        end else cmd.wsel = sha256_pkg::WSEL_ZERO;
        if (status.block_full) begin
          cmd.start = 1'b1;
          rcount_next = '0;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.round = 1'b1;
        rcount_next = rcount + 6'd1;
        if (rcount == 6'd63) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        if (lastblk) begin
          lastblk_next = 1'b0;
          state_next = S_EMIT;
        end else if (pad_pend) state_next = S_PADW;
        else if (padding) state_next = S_FILL;
        else state_next = S_IDLE;
      end
      S_EMIT: begin
        if (!out_stall) begin
          idx_next = idx + 3'd1;
          if (idx == 3'd7) begin
            cmd.clear = 1'b1;
            idx_next = '0;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rcount <= '0;
      padding <= 1'b0;
      pad_pend <= 1'b0;
      len_hi <= 1'b0;
      idx <= '0;
      lastblk <= 1'b0;
    end else begin
      state <= state_next;
      rcount <= rcount_next;
      padding <= padding_next;
      pad_pend <= pad_pend_next;
      len_hi <= len_hi_next;
      idx <= idx_next;
      lastblk <= lastblk_next;
    end
  end

endmodule

>>> hdl/sha256_message_hasher_core.sv
// SHA-256 message hasher top level: controller plus datapath.
// A word that completes a block starts 64 rounds in the single round unit, then a finish
// step; other words are just buffered. A final word adds padding pushes, one or two blocks,
// then eight digest words at one per cycle while out_stall is low. Input stalls until idle.
// Synchronous active-high reset restores the initial hash and clears all counts.
module sha256_message_hasher_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha256_pkg::in_req_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sha256_pkg::out_req_t out_data
);

  sha256_pkg::dp_cmd_t    cmd;
  sha256_pkg::dp_status_t status;
  logic [31:0]            digest_word;
  logic [2:0]             out_index;

  sha256_control u_ctrl (
    .clk, .rst, .in_valid, .req(in_data), .in_stall, .out_stall, .out_valid,
    .out_index, .cmd, .status
  );

  sha256_datapath u_dp (
    .clk, .rst, .cmd, .req(in_data), .status, .digest_word
  );

  assign out_data.digest_word = digest_word;
  assign out_data.word_index = out_index;
  assign out_data.last_digest_word = (out_index == 3'd7);

endmodule
